// ----- hdl/fqd_pkg.sv -----
package fqd_pkg;

	// default geometry of the store
	localparam int DEPTH_DEF        = 16;
	localparam int HANDLE_WIDTH_DEF = 32;
	localparam int COUNT_W_DEF      = $clog2(DEPTH_DEF + 1);

	// fixed field widths on the channels
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_ENQ = 2'd0,
		OP_DEQ = 2'd1,
		OP_DEL = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_NULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_FULL     = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DEQ,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

// ----- hdl/fqd_cmd_if.sv -----
interface fqd_cmd_if
	import fqd_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [VALUE_W-1:0] item_value;

	modport source (output valid, output operation, output item_value, input ready);
	modport sink   (input valid, input operation, input item_value, output ready);
endinterface

// ----- hdl/fqd_rsp_if.sv -----
interface fqd_rsp_if
	import fqd_pkg::*;
#(
	parameter int COUNT_W = COUNT_W_DEF
);
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  result_value;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output status, output result_value, output entry_count,
		input ready);
	modport sink   (input valid, input status, input result_value, input entry_count,
		output ready);
endinterface

// ----- hdl/fqd_ram.sv -----
module fqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/fqd_step_unit.sv -----
module fqd_step_unit #(
	parameter int DEPTH        = 16,
	parameter int HANDLE_WIDTH = 32,
	localparam int AW          = $clog2(DEPTH),
	localparam int CW          = $clog2(DEPTH + 1)
) (
	input  logic [AW-1:0]           base,
	input  logic [CW-1:0]           offset,
	input  logic [HANDLE_WIDTH-1:0] lhs,
	input  logic [HANDLE_WIDTH-1:0] rhs,
	output logic [AW-1:0]           addr,
	output logic                    match
);

	logic [CW:0] sum;
	logic [CW:0] wrapped;

	// ring address: base + offset, folded once back into the store
	always_comb begin
		sum     = (CW + 1)'(base) + (CW + 1)'(offset);
		wrapped = (sum >= (CW + 1)'(DEPTH)) ? sum - (CW + 1)'(DEPTH) : sum;
		addr    = wrapped[AW-1:0];
	end

	// handle compare for the search
	assign match = (lhs == rhs);

endmodule

// ----- hdl/fifo_queue_with_delete_top.sv -----
// Flow: enqueue, op code 3 and the null, empty and full errors pass from accept through
// the execute and done states; dequeue adds a read state; delete walks the held entries
// one entry a cycle in the search and shift loop on the store's single read port.
// One item at a time; cmd.ready is high only while the sequencer idles.
// Reset: clears held count, ring head and output valid; the store is not cleared.
module fifo_queue_with_delete_top
	import fqd_pkg::*;
#(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	fqd_cmd_if.sink  cmd,
	fqd_rsp_if.source rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           head_q;
	logic [AW-1:0]           rptr_q;
	logic [AW-1:0]           wptr_q;
	logic [CW-1:0]           idx_q;
	op_t                     op_q;
	logic [HANDLE_WIDTH-1:0] h_q;
	status_t                 status_q;
	logic [HANDLE_WIDTH-1:0] result_q;

	logic                    ovalid_q;
	status_t                 ostat_q;
	logic [HANDLE_WIDTH-1:0] ores_q;
	logic [CW-1:0]           ocnt_q;

	logic [63:0]             in_wide;
	logic [63:0]             res_wide;
	logic [HANDLE_WIDTH-1:0] h_in;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [HANDLE_WIDTH-1:0] ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [HANDLE_WIDTH-1:0] ram_rdata;

	logic [AW-1:0]           unit_base;
	logic [CW-1:0]           unit_offset;
	logic [AW-1:0]           unit_addr;
	logic                    unit_match;

	logic                    accept;
	logic                    h_null;
	logic                    empty;
	logic                    full;
	logic                    scan_last;
	logic                    shift_last;
	logic                    slot_free;

	// handle taken in its low bits, result zero-extended to the field
	assign in_wide            = {32'b0, cmd.item_value};
	assign h_in               = in_wide[HANDLE_WIDTH-1:0];
	assign res_wide           = 64'(ores_q);

	assign accept     = cmd.valid && cmd.ready;
	assign h_null     = (h_q == '0);
	assign empty      = (cnt_q == '0);
	assign full       = (cnt_q == CW'(DEPTH));
	assign scan_last  = ((idx_q + CW'(1)) == cnt_q);
	assign shift_last = ((idx_q + CW'(2)) == cnt_q);
	assign slot_free  = !ovalid_q || rsp.ready;

	fqd_ram #(
		.WIDTH (HANDLE_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fqd_step_unit #(
		.DEPTH        (DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_step (
		.base   (unit_base),
		.offset (unit_offset),
		.lhs    (ram_rdata),
		.rhs    (h_q),
		.addr   (unit_addr),
		.match  (unit_match)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (op_q)
					OP_DEQ: state_d = empty ? S_DONE : S_DEQ;
					OP_DEL: state_d = (h_null || empty) ? S_DONE : S_SCAN;
					default: state_d = S_DONE;
				endcase
			end
			S_DEQ: state_d = S_DONE;
			S_SCAN: begin
				if (scan_last) begin
					state_d = S_DONE;
				end else if (unit_match) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (shift_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: store ports and shared unit operands
	always_comb begin
		cmd.ready   = (state_q == S_IDLE);
		ram_we      = 1'b0;
		ram_waddr   = unit_addr;
		ram_wdata   = h_q;
		ram_re      = 1'b0;
		ram_raddr   = unit_addr;
		unit_base   = rptr_q;
		unit_offset = CW'(1);
		unique case (state_q)
			S_EXEC: begin
				unit_base   = head_q;
				unit_offset = cnt_q;
				ram_we      = (op_q == OP_ENQ) && !h_null && !full;
				ram_re      = 1'b1;
				ram_raddr   = head_q;
			end
			S_SCAN: begin
				ram_re = 1'b1;
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = wptr_q;
				ram_wdata = ram_rdata;
				ram_re    = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			head_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a new result refills the slot in the cycle the old one leaves
			if ((state_q == S_DONE) && slot_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_EXEC: begin
					if ((op_q == OP_ENQ) && !h_null && !full) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_DEQ: begin
					head_q <= unit_addr;
					cnt_q  <= cnt_q - CW'(1);
				end
				S_SCAN: begin
					if (unit_match && scan_last) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_SHIFT: begin
					if (shift_last) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item payload, search pointers and result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op_t'(cmd.operation);
			h_q      <= h_in;
			status_q <= ST_OK;
			result_q <= '0;
		end
		unique case (state_q)
			S_EXEC: begin
				rptr_q <= head_q;
				idx_q  <= '0;
				unique case (op_q)
					OP_ENQ: begin
						if (h_null) begin
							status_q <= ST_NULL;
						end else if (full) begin
							status_q <= ST_FULL;
						end
					end
					OP_DEQ: begin
						if (empty) begin
							status_q <= ST_EMPTY;
						end
					end
					OP_DEL: begin
						if (h_null) begin
							status_q <= ST_NULL;
						end else if (empty) begin
							status_q <= ST_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			S_DEQ: begin
				result_q <= ram_rdata;
			end
			S_SCAN: begin
				rptr_q <= unit_addr;
				if (unit_match) begin
					wptr_q <= rptr_q;
				end else begin
					idx_q <= idx_q + CW'(1);
					if (scan_last) begin
						status_q <= ST_NOTFOUND;
					end
				end
			end
			S_SHIFT: begin
				wptr_q <= rptr_q;
				rptr_q <= unit_addr;
				idx_q  <= idx_q + CW'(1);
			end
			S_DONE: begin
				if (slot_free) begin
					ostat_q <= status_q;
					ores_q  <= result_q;
					ocnt_q  <= cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.status       = ostat_q;
	assign rsp.result_value = res_wide[VALUE_W-1:0];
	assign rsp.entry_count  = ocnt_q;

`ifndef NO_ASSERTIONS
	// never more entries than slots
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("held count beyond depth");

	// search and shift stay inside the held entries
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SHIFT) |-> (idx_q < cnt_q))
		else $error("search index past held entries");

	// count moves only while an item is being worked
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |=> $stable(cnt_q))
		else $error("held count changed outside an item");

	// a returned handle comes only with an ok status
	a_res_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.result_value != '0) |-> (rsp.status == ST_OK))
		else $error("handle returned with error status");
`endif

endmodule

// ----- sim/tb_top.sv -----
module tb_top
	import fqd_pkg::*;
;

	localparam int DEPTH         = DEPTH_DEF;
	localparam int COUNT_W       = COUNT_W_DEF;
	localparam int RANDOM_ITEMS  = 600;
	localparam int CALM_FROM     = 520;
	localparam int HOLD_AT_ITEM  = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int RECENT_MAX    = 24;
	// operation code with no function; the block must leave the store alone
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// one expected result
	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
	} rsp_item_t;

	// mirrors the handle store and keeps the results still owed by the block
	class handle_queue_tracker;
		logic [VALUE_W-1:0] mirror_q[$];
		rsp_item_t          awaited[$];
		int                 errors;
		int                 checked;
		int                 status_seen[5];
		int                 peak_fill;

		function void take_command(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
			rsp_item_t e;
			bit        found;
			e.status = ST_OK;
			e.value  = '0;
			case (op)
				OP_ENQ: begin
					if (val == '0)
						e.status = ST_NULL;
					else if (mirror_q.size() >= DEPTH)
						e.status = ST_FULL;
					else
						mirror_q.push_back(val);
				end
				OP_DEQ: begin
					if (mirror_q.size() == 0)
						e.status = ST_EMPTY;
					else
						e.value = mirror_q.pop_front();
				end
				OP_DEL: begin
					// null is checked before emptiness; oldest equal entry goes
					if (val == '0)
						e.status = ST_NULL;
					else if (mirror_q.size() == 0)
						e.status = ST_EMPTY;
					else begin
						found = 1'b0;
						foreach (mirror_q[i]) begin
							if (!found && mirror_q[i] == val) begin
								mirror_q.delete(i);
								found = 1'b1;
								break;
							end
						end
						if (!found)
							e.status = ST_NOTFOUND;
					end
				end
				default: ;
			endcase
			e.count = COUNT_W'(mirror_q.size());
			if (mirror_q.size() > peak_fill)
				peak_fill = mirror_q.size();
			awaited.push_back(e);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] rv,
			logic [COUNT_W-1:0] cnt);
			rsp_item_t e;
			if (awaited.size() == 0) begin
				$error("result with none pending: status %0d value %h count %0d",
					st, rv, cnt);
				errors++;
				return;
			end
			e = awaited.pop_front();
			checked++;
			if (e.status <= ST_NOTFOUND)
				status_seen[e.status]++;
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
			if (rv !== e.value) begin
				$error("result_value: expected %h, actual %h", e.value, rv);
				errors++;
			end
			if (cnt !== e.count) begin
				$error("entry_count: expected %0d, actual %0d", e.count, cnt);
				errors++;
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	bit   calm;
	bit   gaps_on;
	bit   hold_req;

	handle_queue_tracker tracker = new();

	fqd_cmd_if cmd_ch ();
	fqd_rsp_if #(.COUNT_W(COUNT_W)) rsp_ch ();

	fifo_queue_with_delete_top #(
		.DEPTH        (DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH_DEF)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reset, once
	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[fifo_queue_with_delete_top] ERROR");
			$finish;
		end
	end

	// observe both channels; values seen here are the ones the edge sampled
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_result(rsp_ch.status, rsp_ch.result_value, rsp_ch.entry_count);
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			tracker.take_command(cmd_ch.operation, cmd_ch.item_value);
	end

	// offer one item, with an optional gap first, and hold it until taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
		if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.operation  <= op;
		cmd_ch.item_value <= val;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	// result side: stall bursts, stall-free stretches, one long hold-off
	initial begin
		int stretch;
		bit stalls_on;
		stretch   = 0;
		stalls_on = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (stretch == 0) begin
					stretch   = $urandom_range(20, 120);
					stalls_on = ($urandom_range(0, 2) != 0);
				end
				stretch--;
				if (!calm && stalls_on && $urandom_range(0, 5) == 0) begin
					rsp_ch.ready <= 1'b0;
					repeat ($urandom_range(1, 16)) @(posedge clk);
				end else begin
					rsp_ch.ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] val;
		logic [VALUE_W-1:0] recent[$];
		int                 mode;
		int                 r;

		cmd_ch.valid      = 1'b0;
		cmd_ch.operation  = OP_ENQ;
		cmd_ch.item_value = '0;
		calm     = 1'b0;
		gaps_on  = 1'b1;
		hold_req = 1'b0;
		mode     = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// errors on an empty store, then order and duplicates
		send_item(OP_ENQ, 32'h0);
		send_item(OP_DEQ, 32'hDEAD_BEEF);
		send_item(OP_DEL, 32'h0);
		send_item(OP_DEL, 32'h5);
		send_item(OP_UNUSED, 32'h1234_5678);
		send_item(OP_ENQ, 32'hFFFF_FFFF);
		send_item(OP_ENQ, 32'h1);
		send_item(OP_ENQ, 32'h5);
		send_item(OP_ENQ, 32'h1);
		send_item(OP_DEL, 32'h1);
		send_item(OP_DEL, 32'h7);
		send_item(OP_DEQ, 32'h0);
		send_item(OP_UNUSED, 32'h0);
		// fill to the top, overflow, then take out tail and head
		for (int i = 0; i < DEPTH - 2; i++)
			send_item(OP_ENQ, (i % 2) ? 32'hAAAA_AAAA - i : 32'h5555_5555 + i);
		send_item(OP_ENQ, 32'h8000_0000);
		send_item(OP_DEL, 32'h0);
		send_item(OP_DEL, 32'hAAAA_AAAA - (DEPTH - 3));
		send_item(OP_DEL, 32'h5);
		send_item(OP_DEQ, 32'hFFFF_FFFF);

		// random mix in phases of fill, drain and balance
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				mode    = $urandom_range(0, 2);
				gaps_on = ($urandom_range(0, 2) != 0);
			end
			if (n == HOLD_AT_ITEM)
				hold_req = 1'b1;
			if (n == CALM_FROM)
				calm = 1'b1;

			r = $urandom_range(0, 99);
			if (r < 3)
				op = OP_UNUSED;
			else if (r < (mode == 0 ? 68 : mode == 1 ? 28 : 48))
				op = OP_ENQ;
			else if (r < (mode == 0 ? 83 : mode == 1 ? 63 : 73))
				op = OP_DEQ;
			else
				op = OP_DEL;

			r = $urandom_range(0, 19);
			if (op == OP_DEL && recent.size() > 0 && $urandom_range(0, 1) == 1)
				val = recent[$urandom_range(0, recent.size() - 1)];
			else if (r < 2)
				val = '0;
			else if (r < 6)
				val = $urandom;
			else
				val = $urandom_range(1, 12);

			if (op == OP_ENQ && val != '0) begin
				recent.push_back(val);
				if (recent.size() > RECENT_MAX)
					void'(recent.pop_front());
			end
			send_item(op, val);
		end
		cmd_ch.valid <= 1'b0;

		// wait for the block to drain, then a few more cycles
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d results checked; ok %0d, null %0d, empty %0d, full %0d, missing %0d",
			tracker.checked, tracker.status_seen[ST_OK], tracker.status_seen[ST_NULL],
			tracker.status_seen[ST_EMPTY], tracker.status_seen[ST_FULL],
			tracker.status_seen[ST_NOTFOUND]);
		$display("Store filled up to %0d of %0d entries", tracker.peak_fill, DEPTH);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("[fifo_queue_with_delete_top] OK");
		else
			$display("[fifo_queue_with_delete_top] ERROR");
		$finish;
	end

endmodule
